// ===== rtl/sgb_pkg.sv =====
// package for the scanline gap bridge: register codes, record type and the
// shared run counter update used on rows and columns
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sgb_pkg;

   localparam int DEF_MAX_COLS    = 4096;
   localparam int DEF_MAX_ROWS    = 4096;
   localparam int DEF_QUEUE_DEPTH = 4;

   localparam int PIXEL_W = 16;
   localparam int LIMIT_W = 8;
   localparam int SIZE_W  = 13;
   localparam int POS_W   = 12;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_GAP_LIMIT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_COLS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_ROWS = 2'd2;

   localparam logic DIR_ROW = 1'b0;
   localparam logic DIR_COL = 1'b1;

   // both events caused by one pixel
   typedef struct packed {
      logic               r_hit;
      logic [POS_W-1:0]   r_row;
      logic [POS_W-1:0]   r_col;
      logic [LIMIT_W-1:0] r_len;
      logic               c_hit;
      logic [POS_W-1:0]   c_row;
      logic [POS_W-1:0]   c_col;
      logic [LIMIT_W-1:0] c_len;
   } rec_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] infl;
      logic               saw;
      logic               cand;
      logic [LIMIT_W-1:0] len;
   } track_type;

   // counter update; len is the unclipped gap length when cand is set
   function automatic track_type track_step(input logic [LIMIT_W-1:0] infl,
                                            input logic saw,
                                            input logic nonzero,
                                            input logic [LIMIT_W-1:0] limit);
      track_type t;
      t.cand = 1'b0;
      t.len  = limit - infl;
      if (!nonzero) begin
         t.saw  = 1'b1;
         t.infl = (infl != '0) ? infl - 1'b1 : infl;
      end else begin
         t.cand = (infl != '0) && saw && (infl < limit);
         t.infl = limit;
         t.saw  = 1'b0;
      end
      return t;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/sgb_front.sv =====
// front end: control registers, raster position, column state store and
// gap detection; produces one record per pixel that closes a gap
// depends on sgb_pkg
`timescale 1ns / 1ps
`default_nettype none
module sgb_front import sgb_pkg::*; #(
   parameter int MAX_COLS = DEF_MAX_COLS,
   parameter int MAX_ROWS = DEF_MAX_ROWS
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_push,
   output      logic                        req_full,
   input  wire logic signed [PIXEL_W-1:0]   req_pixel,
   input  wire logic                        csr_write,
   input  wire logic [CSR_IDX_W-1:0]        csr_index,
   input  wire logic [SIZE_W-1:0]           csr_wdata,
   input  wire logic                        q_full,
   output      logic                        rec_push,
   output      rec_type                     rec_data
);

   localparam int CW    = $clog2(MAX_COLS);
   localparam int RW    = $clog2(MAX_ROWS);
   localparam int PMAXW = (CW > RW) ? CW : RW;
   localparam int CMPW  = ((PMAXW > SIZE_W) ? PMAXW : SIZE_W) + 1;
   localparam int CLW   = (CW > LIMIT_W) ? CW : LIMIT_W;
   localparam int RLW   = (RW > LIMIT_W) ? RW : LIMIT_W;
   localparam int MEMW  = LIMIT_W + 1;

   logic [LIMIT_W-1:0] gap_limit_ff;
   logic [SIZE_W-1:0]  image_cols_ff;
   logic [SIZE_W-1:0]  image_rows_ff;

   logic [CW-1:0]      cur_col_ff, cur_col_in;
   logic [RW-1:0]      cur_row_ff, cur_row_in;

   logic               s1_valid_ff;
   logic               s1_nz_ff;
   logic [CW-1:0]      s1_col_ff;
   logic [RW-1:0]      s1_row_ff;
   logic [MEMW-1:0]    s1_rd_ff;
   logic               s1_known_ff;
   logic               s1_byp_ff;
   logic [MEMW-1:0]    s1_byp_data_ff;

   logic [LIMIT_W-1:0] row_infl_ff;
   logic               row_saw_ff;

   // columns below the fill mark have been written since reset
   logic [CW:0]        fill_ff;

   logic [MEMW-1:0]    col_mem [MAX_COLS];

   logic               accept, fire;
   logic [CMPW-1:0]    cols_eff, rows_eff;
   logic               col_wrap, row_wrap;

   logic [LIMIT_W-1:0] ri, ci;
   logic               rs, cs;
   logic [MEMW-1:0]    col_raw;
   track_type          rt, ct;
   logic [LIMIT_W-1:0] r_len, c_len;
   logic               r_hit, c_hit;
   logic [CLW-1:0]     r_diff;
   logic [RLW-1:0]     c_diff;
   logic [MEMW-1:0]    col_new;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gap_limit_ff  <= LIMIT_W'(8);
         image_cols_ff <= SIZE_W'(1024);
         image_rows_ff <= SIZE_W'(1024);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_GAP_LIMIT:  gap_limit_ff  <= csr_wdata[LIMIT_W-1:0];
            CSR_IMAGE_COLS: image_cols_ff <= csr_wdata;
            CSR_IMAGE_ROWS: image_rows_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign fire     = s1_valid_ff && !q_full;
   assign req_full = s1_valid_ff && !fire;
   assign accept   = req_push && !req_full;

   // raster position
   always_comb begin
      priority if (image_cols_ff == '0)
         cols_eff = CMPW'(1);
      else if (CMPW'(image_cols_ff) > CMPW'(MAX_COLS))
         cols_eff = CMPW'(MAX_COLS);
      else
         cols_eff = CMPW'(image_cols_ff);
      priority if (image_rows_ff == '0)
         rows_eff = CMPW'(1);
      else if (CMPW'(image_rows_ff) > CMPW'(MAX_ROWS))
         rows_eff = CMPW'(MAX_ROWS);
      else
         rows_eff = CMPW'(image_rows_ff);
      col_wrap = (CMPW'(cur_col_ff) + CMPW'(1)) >= cols_eff;
      row_wrap = (CMPW'(cur_row_ff) + CMPW'(1)) >= rows_eff;
      cur_col_in = col_wrap ? '0 : cur_col_ff + 1'b1;
      cur_row_in = !col_wrap ? cur_row_ff : (row_wrap ? '0 : cur_row_ff + 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff  <= '0;
         cur_row_ff  <= '0;
         s1_valid_ff <= 1'b0;
         row_infl_ff <= '0;
         row_saw_ff  <= 1'b0;
         fill_ff     <= '0;
      end else begin
         if (accept) begin
            cur_col_ff <= cur_col_in;
            cur_row_ff <= cur_row_in;
         end
         if (accept)
            s1_valid_ff <= 1'b1;
         else if (fire)
            s1_valid_ff <= 1'b0;
         if (fire) begin
            row_infl_ff <= rt.infl;
            row_saw_ff  <= rt.saw;
         end
         if (fire && ((CW+1)'(s1_col_ff) == fill_ff))
            fill_ff <= fill_ff + 1'b1;
      end
   end

   // column state store, read on transfer in, written when the pixel leaves
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_nz_ff       <= (req_pixel != '0);
         s1_col_ff      <= cur_col_ff;
         s1_row_ff      <= cur_row_ff;
         s1_rd_ff       <= col_mem[cur_col_ff];
         s1_known_ff    <= ((CW+1)'(cur_col_ff) < fill_ff);
         s1_byp_ff      <= fire && (s1_col_ff == cur_col_ff);
         s1_byp_data_ff <= col_new;
      end
      if (fire)
         col_mem[s1_col_ff] <= col_new;
   end

   // gap detection
   always_comb begin
      ri      = (s1_col_ff == '0) ? '0 : row_infl_ff;
      rs      = (s1_col_ff == '0) ? 1'b0 : row_saw_ff;
      col_raw = s1_byp_ff ? s1_byp_data_ff : (s1_known_ff ? s1_rd_ff : '0);
      ci      = (s1_row_ff == '0) ? '0 : col_raw[MEMW-1:1];
      cs      = (s1_row_ff == '0) ? 1'b0 : col_raw[0];
      rt      = track_step(ri, rs, s1_nz_ff, gap_limit_ff);
      ct      = track_step(ci, cs, s1_nz_ff, gap_limit_ff);
      col_new = {ct.infl, ct.saw};

      r_len = (CLW'(rt.len) > CLW'(s1_col_ff)) ? LIMIT_W'(s1_col_ff) : rt.len;
      c_len = (RLW'(ct.len) > RLW'(s1_row_ff)) ? LIMIT_W'(s1_row_ff) : ct.len;
      r_hit = rt.cand && (r_len != '0);
      c_hit = ct.cand && (c_len != '0);
      r_diff = CLW'(s1_col_ff) - CLW'(r_len);
      c_diff = RLW'(s1_row_ff) - RLW'(c_len);

      rec_data.r_hit = r_hit;
      rec_data.r_row = POS_W'(s1_row_ff);
      rec_data.r_col = POS_W'(r_diff);
      rec_data.r_len = r_len;
      rec_data.c_hit = c_hit;
      rec_data.c_row = POS_W'(c_diff);
      rec_data.c_col = POS_W'(s1_col_ff);
      rec_data.c_len = c_len;
      rec_push = fire && (r_hit || c_hit);
   end

endmodule
`default_nettype wire

// ===== rtl/sgb_queue.sv =====
// short record queue between the gap detector and the event output
// depends on sgb_pkg
`timescale 1ns / 1ps
`default_nettype none
module sgb_queue import sgb_pkg::*; #(
   parameter int DEPTH = DEF_QUEUE_DEPTH
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    wr_en,
   input  wire rec_type wr_data,
   output      logic    q_full,
   output      logic    q_empty,
   input  wire logic    rd_en,
   output      rec_type rd_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   rec_type        store [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [NW-1:0]  count_ff;
   logic           do_wr, do_rd;

   assign q_full  = (count_ff == NW'(DEPTH));
   assign q_empty = (count_ff == '0);
   assign do_wr   = wr_en && !q_full;
   assign do_rd   = rd_en && !q_empty;
   assign rd_data = store[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_wr)
         store[wr_ptr_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr)
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         if (do_rd)
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         if (do_wr && !do_rd)
            count_ff <= count_ff + 1'b1;
         else if (do_rd && !do_wr)
            count_ff <= count_ff - 1'b1;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/sgb_back.sv =====
// back end: splits each queued record into its row and column events
// depends on sgb_pkg
`timescale 1ns / 1ps
`default_nettype none
module sgb_back import sgb_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_empty,
   input  wire rec_type             q_head,
   output      logic                q_pop,
   output      logic                rsp_empty,
   input  wire logic                rsp_pop,
   output      logic                rsp_direction,
   output      logic [POS_W-1:0]    rsp_gap_row,
   output      logic [POS_W-1:0]    rsp_gap_col,
   output      logic [LIMIT_W-1:0]  rsp_gap_length,
   output      logic                rsp_last
);

   logic half_ff;
   logic sel_row, xfer;

   assign sel_row   = q_head.r_hit && !half_ff;
   assign rsp_empty = q_empty;
   assign xfer      = rsp_pop && !q_empty;

   always_comb begin
      if (sel_row) begin
         rsp_direction  = DIR_ROW;
         rsp_gap_row    = q_head.r_row;
         rsp_gap_col    = q_head.r_col;
         rsp_gap_length = q_head.r_len;
         rsp_last       = !q_head.c_hit;
      end else begin
         rsp_direction  = DIR_COL;
         rsp_gap_row    = q_head.c_row;
         rsp_gap_col    = q_head.c_col;
         rsp_gap_length = q_head.c_len;
         rsp_last       = 1'b1;
      end
      q_pop = xfer && !(sel_row && q_head.c_hit);
   end

   // set between the two events of one record
   always_ff @(posedge clock) begin
      if (reset)
         half_ff <= 1'b0;
      else if (xfer)
         half_ff <= sel_row && q_head.c_hit;
   end

endmodule
`default_nettype wire

// ===== rtl/scanline_gap_bridge.sv =====
// a pixel is registered, then its record is queued; its events show at the queue head
// one pixel per cycle while the queue has room; a two-event pixel takes two transfers
// the column store is read and written once per pixel, one port each
// reset (synchronous): resets control registers, clears position, row state, fill
// mark and queue; the column store is not cleared, columns past the mark read as zero
`timescale 1ns / 1ps
`default_nettype none
module scanline_gap_bridge import sgb_pkg::*; #(
   parameter int MAX_COLS    = DEF_MAX_COLS,
   parameter int MAX_ROWS    = DEF_MAX_ROWS,
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_push,
   output      logic                       req_full,
   input  wire logic signed [PIXEL_W-1:0]  req_pixel,
   output      logic                       rsp_empty,
   input  wire logic                       rsp_pop,
   output      logic                       rsp_direction,
   output      logic [POS_W-1:0]           rsp_gap_row,
   output      logic [POS_W-1:0]           rsp_gap_col,
   output      logic [LIMIT_W-1:0]         rsp_gap_length,
   output      logic                       rsp_last,
   input  wire logic                       csr_write,
   input  wire logic [CSR_IDX_W-1:0]       csr_index,
   input  wire logic [SIZE_W-1:0]          csr_wdata
);

   logic    q_full, q_empty, q_pop, rec_push;
   rec_type rec_data, q_head;

   sgb_front #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_pixel (req_pixel),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_full    (q_full),
      .rec_push  (rec_push),
      .rec_data  (rec_data)
   );

   sgb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rec_push),
      .wr_data (rec_data),
      .q_full  (q_full),
      .q_empty (q_empty),
      .rd_en   (q_pop),
      .rd_data (q_head)
   );

   sgb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_direction  (rsp_direction),
      .rsp_gap_row    (rsp_gap_row),
      .rsp_gap_col    (rsp_gap_col),
      .rsp_gap_length (rsp_gap_length),
      .rsp_last       (rsp_last)
   );

endmodule
`default_nettype wire

// ===== verif/scanline_gap_bridge_tb.sv =====
// testbench for scanline_gap_bridge: directed table then random frames, every gap
// event checked in order vs table entries or a predictor of row and column runs
// depends on rtl/sgb_pkg.sv and rtl/scanline_gap_bridge.sv
`timescale 1ns / 1ps
module scanline_gap_bridge_tb;
   import sgb_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic               dir;
      logic [POS_W-1:0]   row;
      logic [POS_W-1:0]   col;
      logic [LIMIT_W-1:0] len;
      logic               last;
   } gap_event_type;

   typedef enum logic [1:0] {BY_MODEL, NO_EVENT, ONE_EVENT} check_mode_type;
   typedef enum logic {STEP_PIXEL, STEP_REG} step_kind_type;

   typedef struct packed {
      step_kind_type          kind;
      logic [CSR_IDX_W-1:0]   idx;
      logic [PIXEL_W-1:0]     value;
      check_mode_type         mode;
      gap_event_type          ev;
   } plan_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_push = 1'b0;
   logic                      req_full;
   logic signed [PIXEL_W-1:0] req_pixel = '0;
   logic                      rsp_empty;
   logic                      rsp_pop = 1'b0;
   logic                      rsp_direction;
   logic [POS_W-1:0]          rsp_gap_row;
   logic [POS_W-1:0]          rsp_gap_col;
   logic [LIMIT_W-1:0]        rsp_gap_length;
   logic                      rsp_last;
   logic                      csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = CSR_GAP_LIMIT;
   logic [SIZE_W-1:0]         csr_wdata = '0;

   scanline_gap_bridge dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_pixel(req_pixel),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_direction(rsp_direction), .rsp_gap_row(rsp_gap_row),
      .rsp_gap_col(rsp_gap_col), .rsp_gap_length(rsp_gap_length),
      .rsp_last(rsp_last),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   // predictor state
   logic [LIMIT_W-1:0] cfg_limit;
   logic [SIZE_W-1:0]  cfg_cols;
   logic [SIZE_W-1:0]  cfg_rows;
   int                 pos_row, pos_col;
   logic [LIMIT_W-1:0] row_count;
   bit                 row_zero;
   logic [LIMIT_W-1:0] col_count [DEF_MAX_COLS];
   bit                 col_zero [DEF_MAX_COLS];

   gap_event_type gaps_due[$];
   gap_event_type got_gap, due_gap;
   plan_row_type  plan [32];
   int            plan_len = 0;

   int  error_count = 0;
   int  events_checked = 0;
   int  row_gaps = 0, col_gaps = 0;
   int  pixels_sent = 0, reg_writes = 0, random_items = 0;
   int  pop_hold = 0;
   int  idle_cycles = 0;
   bit  calm = 1'b0;

   task automatic report_error(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic string describe(input gap_event_type e);
      return $sformatf("dir %0d row %0d col %0d len %0d last %0d",
                       e.dir, e.row, e.col, e.len, e.last);
   endfunction

   function automatic int extent(input logic [SIZE_W-1:0] v, input int top);
      if (v == 0) return 1;
      if (v > top) return top;
      return v;
   endfunction

   // one run counter and zero flag; hit when a nonzero pixel closes a short gap
   task automatic close_run(inout logic [LIMIT_W-1:0] cnt, inout bit seen, input bit nz,
                            input logic [LIMIT_W-1:0] lim, input int pos,
                            output bit hit, output int len);
      hit = 1'b0;
      len = 0;
      if (!nz) begin
         seen = 1'b1;
         if (cnt != 0) cnt = cnt - 1'b1;
      end else begin
         if (cnt != 0 && seen && cnt < lim) begin
            len = int'(lim) - int'(cnt);
            if (len > pos) len = pos;
            hit = (len > 0);
         end
         cnt = lim;
         seen = 1'b0;
      end
   endtask

   task automatic predict_gaps(input logic [PIXEL_W-1:0] px, input bit enqueue);
      logic [LIMIT_W-1:0] cnt;
      bit                 seen, nz, rhit, chit;
      int                 rlen, clen;
      gap_event_type      rev, cev;
      nz = (px != 0);
      cnt = (pos_col == 0) ? '0 : row_count;
      seen = (pos_col == 0) ? 1'b0 : row_zero;
      close_run(cnt, seen, nz, cfg_limit, pos_col, rhit, rlen);
      row_count = cnt;
      row_zero = seen;
      cnt = (pos_row == 0) ? '0 : col_count[pos_col];
      seen = (pos_row == 0) ? 1'b0 : col_zero[pos_col];
      close_run(cnt, seen, nz, cfg_limit, pos_row, chit, clen);
      col_count[pos_col] = cnt;
      col_zero[pos_col] = seen;
      rev.dir = DIR_ROW;
      rev.row = POS_W'(pos_row);
      rev.col = POS_W'(pos_col - rlen);
      rev.len = LIMIT_W'(rlen);
      rev.last = !chit;
      cev.dir = DIR_COL;
      cev.row = POS_W'(pos_row - clen);
      cev.col = POS_W'(pos_col);
      cev.len = LIMIT_W'(clen);
      cev.last = 1'b1;
      if (rhit) begin
         row_gaps++;
         if (enqueue) gaps_due.push_back(rev);
      end
      if (chit) begin
         col_gaps++;
         if (enqueue) gaps_due.push_back(cev);
      end
      if (pos_col + 1 >= extent(cfg_cols, DEF_MAX_COLS)) begin
         pos_col = 0;
         pos_row = (pos_row + 1 >= extent(cfg_rows, DEF_MAX_ROWS)) ? 0 : pos_row + 1;
      end else begin
         pos_col++;
      end
   endtask

   task automatic push_pixel(input logic [PIXEL_W-1:0] px);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_pixel <= px;
      do @(posedge clock); while (req_full);
      pixels_sent++;
   endtask

   // drain outstanding events, then allow for pixels that made none
   task automatic settle();
      req_push <= 1'b0;
      while (gaps_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [SIZE_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_GAP_LIMIT:  cfg_limit = value[LIMIT_W-1:0];
         CSR_IMAGE_COLS: cfg_cols = value;
         CSR_IMAGE_ROWS: cfg_rows = value;
         default: ;
      endcase
      reg_writes++;
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_frame(input int count, input int pct);
      logic [PIXEL_W-1:0] px;
      for (int k = 0; k < count; k++) begin
         px = PIXEL_W'($urandom);
         if ($urandom_range(0, 99) >= pct) px = '0;
         else if (px == 0) px = 16'h8000;
         push_pixel(px);
         predict_gaps(px, 1'b1);
      end
   endtask

   task automatic add_step(input step_kind_type kind, input logic [CSR_IDX_W-1:0] idx,
                           input logic [PIXEL_W-1:0] value, input check_mode_type mode,
                           input gap_event_type ev);
      plan[plan_len].kind = kind;
      plan[plan_len].idx = idx;
      plan[plan_len].value = value;
      plan[plan_len].mode = mode;
      plan[plan_len].ev = ev;
      plan_len++;
   endtask

   // result side: random pop stalls, in-order check of every transfer
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         got_gap = {rsp_direction, rsp_gap_row, rsp_gap_col, rsp_gap_length, rsp_last};
         if (gaps_due.size() == 0) begin
            report_error($sformatf("unexpected event: %s", describe(got_gap)));
         end else begin
            due_gap = gaps_due.pop_front();
            events_checked++;
            if (got_gap !== due_gap)
               report_error($sformatf("got %s, want %s", describe(got_gap), describe(due_gap)));
         end
      end
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (pop_hold > 0) begin
         pop_hold--;
         rsp_pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         pop_hold = $urandom_range(0, 9);
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles, %0d events outstanding",
                     idle_cycles, gaps_due.size());
            $display("scanline_gap_bridge_tb: errors");
            $finish;
         end
      end
   end

   initial begin
      logic [SIZE_W-1:0] lv, cv, rv;
      int                pick;
      cfg_limit = 8'd8;
      cfg_cols = 13'd1024;
      cfg_rows = 13'd1024;
      pos_row = 0;
      pos_col = 0;
      row_count = '0;
      row_zero = 1'b0;
      for (int c = 0; c < DEF_MAX_COLS; c++) begin
         col_count[c] = '0;
         col_zero[c] = 1'b0;
      end

      // 4 x 4 frame, limit 8: leading zeros, sample extremes, both gap kinds
      add_step(STEP_REG, CSR_IMAGE_COLS, 16'd4, BY_MODEL, '0);
      add_step(STEP_REG, CSR_IMAGE_ROWS, 16'd4, BY_MODEL, '0);
      add_step(STEP_PIXEL, CSR_GAP_LIMIT, 16'h8000, NO_EVENT, '0);
      add_step(STEP_PIXEL, CSR_GAP_LIMIT, 16'h0000, NO_EVENT, '0);
      add_step(STEP_PIXEL, CSR_GAP_LIMIT, 16'h0000, NO_EVENT, '0);
      add_step(STEP_PIXEL, CSR_GAP_LIMIT, 16'h7fff, ONE_EVENT,
               {DIR_ROW, 12'd0, 12'd1, 8'd2, 1'b1});
      add_step(STEP_PIXEL, CSR_GAP_LIMIT, 16'h0000, NO_EVENT, '0);
      add_step(STEP_PIXEL, CSR_GAP_LIMIT, 16'h0000, NO_EVENT, '0);
      add_step(STEP_PIXEL, CSR_GAP_LIMIT, 16'h0000, NO_EVENT, '0);
      add_step(STEP_PIXEL, CSR_GAP_LIMIT, 16'hffff, NO_EVENT, '0);
      add_step(STEP_PIXEL, CSR_GAP_LIMIT, 16'h0001, ONE_EVENT,
               {DIR_COL, 12'd1, 12'd0, 8'd1, 1'b1});
      add_step(STEP_PIXEL, CSR_GAP_LIMIT, 16'h0000, BY_MODEL, '0);
      add_step(STEP_PIXEL, CSR_GAP_LIMIT, 16'h0000, BY_MODEL, '0);
      add_step(STEP_PIXEL, CSR_GAP_LIMIT, 16'h0000, BY_MODEL, '0);
      add_step(STEP_PIXEL, CSR_GAP_LIMIT, 16'h0005, BY_MODEL, '0);
      add_step(STEP_PIXEL, CSR_GAP_LIMIT, 16'h0000, BY_MODEL, '0);
      add_step(STEP_PIXEL, CSR_GAP_LIMIT, 16'h0000, BY_MODEL, '0);
      add_step(STEP_PIXEL, CSR_GAP_LIMIT, 16'h0009, BY_MODEL, '0);
      // limit raised mid-row: length clipped at the row start
      add_step(STEP_REG, CSR_GAP_LIMIT, 16'd2, BY_MODEL, '0);
      add_step(STEP_PIXEL, CSR_GAP_LIMIT, 16'h0003, BY_MODEL, '0);
      add_step(STEP_PIXEL, CSR_GAP_LIMIT, 16'h0000, BY_MODEL, '0);
      add_step(STEP_REG, CSR_GAP_LIMIT, 16'd255, BY_MODEL, '0);
      add_step(STEP_PIXEL, CSR_GAP_LIMIT, 16'h0003, BY_MODEL, '0);
      add_step(STEP_PIXEL, CSR_GAP_LIMIT, 16'h0000, BY_MODEL, '0);
      // limit lowered below a stored counter: no event
      add_step(STEP_PIXEL, CSR_GAP_LIMIT, 16'h0007, BY_MODEL, '0);
      add_step(STEP_PIXEL, CSR_GAP_LIMIT, 16'h0000, BY_MODEL, '0);
      add_step(STEP_REG, CSR_GAP_LIMIT, 16'd100, BY_MODEL, '0);
      add_step(STEP_PIXEL, CSR_GAP_LIMIT, 16'h0007, BY_MODEL, '0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < plan_len; i++) begin
         if (plan[i].kind == STEP_REG) begin
            settle();
            write_reg(plan[i].idx, SIZE_W'(plan[i].value));
         end else begin
            push_pixel(plan[i].value);
            predict_gaps(plan[i].value, plan[i].mode == BY_MODEL);
            if (plan[i].mode == ONE_EVENT) gaps_due.push_back(plan[i].ev);
         end
      end

      while (random_items < 800) begin
         settle();
         calm = (random_items >= 650) || ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 6);
         lv = (pick == 0) ? 13'd0 : (pick == 1) ? 13'd1 : (pick == 2) ? 13'd2 :
              (pick == 3) ? 13'd255 : SIZE_W'($urandom_range(3, 254));
         if ($urandom_range(0, 3) == 0) lv[SIZE_W-1:LIMIT_W] = 5'($urandom);
         pick = $urandom_range(0, 9);
         cv = (pick == 0) ? 13'd0 : (pick == 1) ? 13'd1 : (pick == 2) ? 13'd4096 :
              (pick == 3) ? 13'd8191 : SIZE_W'($urandom_range(2, 16));
         pick = $urandom_range(0, 9);
         rv = (pick == 0) ? 13'd0 : (pick == 1) ? 13'd1 : (pick == 2) ? 13'd8191 :
              SIZE_W'($urandom_range(2, 16));
         pick = $urandom_range(1, 7);
         if (pick[0]) write_reg(CSR_GAP_LIMIT, lv);
         if (pick[1]) write_reg(CSR_IMAGE_COLS, cv);
         if (pick[2]) write_reg(CSR_IMAGE_ROWS, rv);
         pick = $urandom_range(20, 100);
         run_frame(pick, $urandom_range(10, 70));
         random_items += pick;
      end

      settle();
      repeat (8) @(posedge clock);
      $display("summary: %0d pixel transfers, %0d register writes, %0d events checked",
               pixels_sent, reg_writes, events_checked);
      $display("summary: %0d row gaps and %0d column gaps predicted", row_gaps, col_gaps);
      if (error_count == 0 && gaps_due.size() == 0) begin
         $display("scanline_gap_bridge_tb: clean");
      end else begin
         $display("scanline_gap_bridge_tb: errors");
      end
      $finish;
   end

endmodule

// ===== scanline_gap_bridge.f =====
rtl/sgb_pkg.sv
rtl/sgb_front.sv
rtl/sgb_queue.sv
rtl/sgb_back.sv
rtl/scanline_gap_bridge.sv
verif/scanline_gap_bridge_tb.sv
